### design/jsiir_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the joint sample IIR low-pass filter.
package jsiir_pkg;

    localparam int JIDX_W    = 3;   // joint index field width
    localparam int COEF_W    = 18;  // signed Q2.16 coefficients
    localparam int FRAC_BITS = 16;
    localparam int CHANNELS  = 3;   // angle, torque, gravity torque

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic signed [COEF_W-1:0] COEF_INPUT_RST  = 18'sd5138;
    localparam logic signed [COEF_W-1:0] COEF_FB_ONE_RST = 18'sd102380;
    localparam logic signed [COEF_W-1:0] COEF_FB_TWO_RST = -18'sd42028;

    typedef enum logic [1:0] {
        REG_COEF_INPUT  = 2'd0,
        REG_COEF_FB_ONE = 2'd1,
        REG_COEF_FB_TWO = 2'd2,
        REG_UNUSED      = 2'd3
    } cfg_reg_t;

endpackage

### design/jsiir_sample_if.sv
`timescale 1ns / 1ps
// Input item channel: one joint sample with valid/ready handshake.
interface jsiir_sample_if
    import jsiir_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic        [JIDX_W-1:0]       joint_index;
    logic signed [SAMPLE_WIDTH-1:0] joint_angle;
    logic signed [SAMPLE_WIDTH-1:0] joint_torque;
    logic signed [SAMPLE_WIDTH-1:0] gravity_torque;

    modport source (output valid, joint_index, joint_angle, joint_torque, gravity_torque,
                    input ready);
    modport sink   (input valid, joint_index, joint_angle, joint_torque, gravity_torque,
                    output ready);
endinterface

### design/jsiir_result_if.sv
`timescale 1ns / 1ps
// Result item channel: one filtered joint sample with valid/ready handshake.
interface jsiir_result_if
    import jsiir_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic        [JIDX_W-1:0]       out_joint_index;
    logic signed [SAMPLE_WIDTH-1:0] filtered_angle;
    logic signed [SAMPLE_WIDTH-1:0] filtered_torque;
    logic signed [SAMPLE_WIDTH-1:0] filtered_gravity;

    modport source (output valid, out_joint_index, filtered_angle, filtered_torque,
                    filtered_gravity, input ready);
    modport sink   (input valid, out_joint_index, filtered_angle, filtered_torque,
                    filtered_gravity, output ready);
endinterface

### design/joint_sample_iir_lowpass.sv
`timescale 1ns / 1ps
// Per-joint second-order IIR low-pass filter over angle, torque and gravity torque.
//
// sample_ch takes one joint sample per item; result_ch returns one filtered item
// per input item, in order. Both use valid/ready; an item moves when both are high.
// The APB port writes and reads the three Q2.16 coefficients (0x0, 0x4, 0x8);
// change them only while no item is in flight.
//
// An accepted input item passes through the input register, then the result
// register, before its result is offered on result_ch. Throughput: 1 item per
// cycle while result_ch does not stall, also for repeated samples of the same
// joint, since the history registers of a joint are read and filtered between
// the two registers and written back when the item enters the result register.
//
// Reset clears both valid flags and the per-joint primed flags and restores the
// default coefficients. The first sample a joint sees after reset primes its
// history with that sample. A joint index at or above JOINT_COUNT gives a result
// with zero samples and leaves all history untouched.
// When result_ch stalls, the result register holds; the input register still
// takes one more item, then sample_ch.ready drops until the result is taken.
module joint_sample_iir_lowpass
    import jsiir_pkg::*;
#(
    parameter int JOINT_COUNT  = 7,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    jsiir_sample_if.sink      sample_ch,
    jsiir_result_if.source    result_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int JW   = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int PW   = SAMPLE_WIDTH + COEF_W;
    localparam int SUMW = PW + 2;
    localparam logic signed [SUMW-1:0] ROUND_HALF = SUMW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [SUMW-1:0] SAT_MAX    = SUMW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [SUMW-1:0] SAT_MIN    = -SAT_MAX - SUMW'(1);

    // ---------------- configuration ----------------
    logic signed [COEF_W-1:0] coef_input_reg;
    logic signed [COEF_W-1:0] coef_fb_one_reg;
    logic signed [COEF_W-1:0] coef_fb_two_reg;
    logic                     cfg_write;
    cfg_reg_t                 cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_input_reg  <= COEF_INPUT_RST;
            coef_fb_one_reg <= COEF_FB_ONE_RST;
            coef_fb_two_reg <= COEF_FB_TWO_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_COEF_INPUT:  coef_input_reg  <= pwdata[COEF_W-1:0];
                REG_COEF_FB_ONE: coef_fb_one_reg <= pwdata[COEF_W-1:0];
                REG_COEF_FB_TWO: coef_fb_two_reg <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_COEF_INPUT:  prdata = APB_DW'(coef_input_reg);
            REG_COEF_FB_ONE: prdata = APB_DW'(coef_fb_one_reg);
            REG_COEF_FB_TWO: prdata = APB_DW'(coef_fb_two_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic in_valid_reg, in_valid_next;
    logic res_valid_reg, res_valid_next;
    logic res_free;
    logic advance;
    logic take_in;

    assign res_free        = !res_valid_reg || result_ch.ready;
    assign advance         = in_valid_reg && res_free;
    assign sample_ch.ready = !in_valid_reg || advance;
    assign take_in         = sample_ch.valid && sample_ch.ready;
    assign in_valid_next   = take_in || (in_valid_reg && !advance);
    assign res_valid_next  = advance || (res_valid_reg && !result_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ---------------- input register ----------------
    logic        [JIDX_W-1:0]       idx_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg [CHANNELS];

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            idx_reg  <= sample_ch.joint_index;
            x_reg[0] <= sample_ch.joint_angle;
            x_reg[1] <= sample_ch.joint_torque;
            x_reg[2] <= sample_ch.gravity_torque;
        end
    end

    // ---------------- per-joint history and filter ----------------
    logic signed [SAMPLE_WIDTH-1:0] xprev_reg [JOINT_COUNT][CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] y1_reg    [JOINT_COUNT][CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] y2_reg    [JOINT_COUNT][CHANNELS];
    logic        [JOINT_COUNT-1:0]  primed_reg;

    logic [JW-1:0]                  jsel;
    logic                           in_range;
    logic                           primed;
    logic                           upd;
    logic signed [SAMPLE_WIDTH-1:0] h_xp [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] h_y1 [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] y    [CHANNELS];

    assign jsel     = JW'(idx_reg);
    assign in_range = 32'(idx_reg) < 32'(JOINT_COUNT);
    assign primed   = primed_reg[jsel];
    assign upd      = advance && in_range;

    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_chan
        logic signed [SAMPLE_WIDTH-1:0] h_y2;
        logic signed [PW-1:0]           p0, p1, p2;
        logic signed [SUMW-1:0]         acc;
        logic signed [SUMW-1:0]         rnd;

        // an unprimed joint uses the current sample for all three history taps
        assign h_xp[ch] = primed ? xprev_reg[jsel][ch] : x_reg[ch];
        assign h_y1[ch] = primed ? y1_reg[jsel][ch]    : x_reg[ch];
        assign h_y2     = primed ? y2_reg[jsel][ch]    : x_reg[ch];

        assign p0  = coef_input_reg  * h_xp[ch];
        assign p1  = coef_fb_one_reg * h_y1[ch];
        assign p2  = coef_fb_two_reg * h_y2;
        assign acc = SUMW'(p0) + SUMW'(p1) + SUMW'(p2) + ROUND_HALF;
        assign rnd = acc >>> FRAC_BITS;

        always_comb
        begin
            priority if (rnd > SAT_MAX)
                y[ch] = SAMPLE_WIDTH'(SAT_MAX);
            else if (rnd < SAT_MIN)
                y[ch] = SAMPLE_WIDTH'(SAT_MIN);
            else
                y[ch] = SAMPLE_WIDTH'(rnd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                xprev_reg[jsel][ch] <= x_reg[ch];
                y2_reg[jsel][ch]    <= h_y1[ch];
                y1_reg[jsel][ch]    <= y[ch];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            primed_reg <= '0;
        else if (upd)
            primed_reg[jsel] <= 1'b1;
    end

    // ---------------- result register ----------------
    logic        [JIDX_W-1:0]       res_idx_reg;
    logic signed [SAMPLE_WIDTH-1:0] res_y_reg [CHANNELS];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_idx_reg <= idx_reg;
            for (int ch = 0; ch < CHANNELS; ch++)
                res_y_reg[ch] <= in_range ? y[ch] : '0;
        end
    end

    assign result_ch.valid            = res_valid_reg;
    assign result_ch.out_joint_index  = res_idx_reg;
    assign result_ch.filtered_angle   = res_y_reg[0];
    assign result_ch.filtered_torque  = res_y_reg[1];
    assign result_ch.filtered_gravity = res_y_reg[2];

    // ---------------- assertions ----------------
    a_bad_joint_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && (32'(result_ch.out_joint_index) >= 32'(JOINT_COUNT)) |->
            (result_ch.filtered_angle == '0) && (result_ch.filtered_torque == '0) &&
            (result_ch.filtered_gravity == '0))
        else $error("out-of-range joint gave nonzero result");

    a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ((primed_reg & $past(primed_reg)) == $past(primed_reg)))
        else $error("joint primed flag cleared without reset");

    a_primed_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> primed_reg[$past(jsel)])
        else $error("joint not primed after its item");

    a_item_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("filtered item lost between registers");

endmodule
